### rtl/core/btsv_pkg.sv
// ----------------------------------------------------------------------------
// btsv_pkg
// Shared types, sizes, opcodes, error codes and type masks of the
// bytecode type-stack verifier.
// ----------------------------------------------------------------------------
package btsv_pkg;

    localparam int STACK_DEPTH = 1024;
    localparam int LOCAL_SLOTS = 64;
    // stack count width: holds 0..STACK_DEPTH
    localparam int SAW = $clog2(STACK_DEPTH + 1);
    // local slot index width
    localparam int LAW = (LOCAL_SLOTS > 1) ? $clog2(LOCAL_SLOTS) : 1;

    localparam logic [31:0] LIMIT_MAX   = 32'd256;
    localparam logic [31:0] RETRY_MAX   = 32'd16;
    localparam logic [31:0] BACKOFF_MAX = 32'd60000;
    localparam logic [31:0] RATE_MAX    = 32'd10000;

    typedef logic [8:0] t_type;
    typedef logic [5:0] t_err;

    localparam t_type T_DOC    = 9'h001;
    localparam t_type T_TEXT   = 9'h002;
    localparam t_type T_STR    = 9'h004;
    localparam t_type T_NULL   = 9'h008;
    localparam t_type T_BOOL   = 9'h010;
    localparam t_type T_I64    = 9'h020;
    localparam t_type T_REC    = 9'h040;
    localparam t_type T_LIST   = 9'h080;
    localparam t_type T_FUT    = 9'h100;
    localparam t_type T_SCALAR = T_TEXT | T_STR | T_NULL | T_BOOL | T_I64;
    localparam t_type T_VALUE  = T_SCALAR | T_REC | T_LIST;
    localparam int    FUT_BIT  = 8;

    localparam logic [7:0] OP_OMNI         = 8'd0;
    localparam logic [7:0] OP_GENESIS      = 8'd1;
    localparam logic [7:0] OP_LIMIT        = 8'd2;
    localparam logic [7:0] OP_RETRY        = 8'd3;
    localparam logic [7:0] OP_BACKOFF      = 8'd4;
    localparam logic [7:0] OP_RATE         = 8'd5;
    localparam logic [7:0] OP_HUNT         = 8'd6;
    localparam logic [7:0] OP_FORK         = 8'd7;
    localparam logic [7:0] OP_CONST        = 8'd8;
    localparam logic [7:0] OP_CONST_NULL   = 8'd9;
    localparam logic [7:0] OP_CONST_BOOL   = 8'd10;
    localparam logic [7:0] OP_CONST_I64    = 8'd11;
    localparam logic [7:0] OP_CONST_RECORD = 8'd12;
    localparam logic [7:0] OP_CONST_LIST   = 8'd13;
    localparam logic [7:0] OP_BIND         = 8'd14;
    localparam logic [7:0] OP_LOAD         = 8'd15;
    localparam logic [7:0] OP_AWAIT        = 8'd16;
    localparam logic [7:0] OP_JOIN         = 8'd17;
    localparam logic [7:0] OP_REAP         = 8'd18;
    localparam logic [7:0] OP_JSON_PATH    = 8'd19;
    localparam logic [7:0] OP_RECORD_SET   = 8'd20;
    localparam logic [7:0] OP_LIST_PUSH    = 8'd21;
    localparam logic [7:0] OP_RECORD_GET   = 8'd22;
    localparam logic [7:0] OP_RECORD_GET_O = 8'd23;
    localparam logic [7:0] OP_LIST_AT      = 8'd24;
    localparam logic [7:0] OP_LIST_AT_O    = 8'd25;
    localparam logic [7:0] OP_BOOL_NOT     = 8'd26;
    localparam logic [7:0] OP_BOOL_AND     = 8'd27;
    localparam logic [7:0] OP_BOOL_OR      = 8'd28;
    localparam logic [7:0] OP_LESS         = 8'd29;
    localparam logic [7:0] OP_LESS_EQUAL   = 8'd30;
    localparam logic [7:0] OP_GREATER      = 8'd31;
    localparam logic [7:0] OP_GREATER_EQ   = 8'd32;
    localparam logic [7:0] OP_EQUAL        = 8'd33;
    localparam logic [7:0] OP_NOT_EQUAL    = 8'd34;
    localparam logic [7:0] OP_COALESCE     = 8'd35;
    localparam logic [7:0] OP_TO_TEXT      = 8'd36;
    localparam logic [7:0] OP_TO_I64       = 8'd37;
    localparam logic [7:0] OP_TO_BOOL      = 8'd38;
    localparam logic [7:0] OP_URL_ENCODE   = 8'd39;
    localparam logic [7:0] OP_URL_JOIN     = 8'd40;
    localparam logic [7:0] OP_HUNT_VALUE   = 8'd41;
    localparam logic [7:0] OP_HOST_CALL    = 8'd42;
    localparam logic [7:0] OP_EMIT         = 8'd43;
    localparam logic [7:0] OP_HALT         = 8'd44;

    localparam t_err E_NONE          = 6'd0;
    localparam t_err E_AFTER_HALT    = 6'd1;
    localparam t_err E_EXEC_NAME     = 6'd2;
    localparam t_err E_GENESIS_TWICE = 6'd3;
    localparam t_err E_CFG_LOCKED    = 6'd4;
    localparam t_err E_LIMIT         = 6'd5;
    localparam t_err E_RETRY         = 6'd6;
    localparam t_err E_BACKOFF       = 6'd7;
    localparam t_err E_RATE          = 6'd8;
    localparam t_err E_NET_EARLY     = 6'd9;
    localparam t_err E_OVERFLOW      = 6'd10;
    localparam t_err E_CONST_EARLY   = 6'd11;
    localparam t_err E_TCONST_EARLY  = 6'd12;
    localparam t_err E_BIND_EMPTY    = 6'd13;
    localparam t_err E_BIND_SLOT     = 6'd14;
    localparam t_err E_LOAD_UNBOUND  = 6'd15;
    localparam t_err E_AWAIT         = 6'd16;
    localparam t_err E_JOIN_COUNT    = 6'd17;
    localparam t_err E_JOIN_TYPE     = 6'd18;
    localparam t_err E_REAP          = 6'd19;
    localparam t_err E_JSON_PATH     = 6'd20;
    localparam t_err E_MUT_COUNT     = 6'd21;
    localparam t_err E_MUT_TYPE      = 6'd22;
    localparam t_err E_REC_READ      = 6'd23;
    localparam t_err E_LIST_READ     = 6'd24;
    localparam t_err E_NOT           = 6'd25;
    localparam t_err E_BOOL_OP       = 6'd26;
    localparam t_err E_ORDER         = 6'd27;
    localparam t_err E_BINARY        = 6'd28;
    localparam t_err E_CONVERT       = 6'd29;
    localparam t_err E_URL_JOIN      = 6'd30;
    localparam t_err E_HUNT_VALUE    = 6'd31;
    localparam t_err E_HOST_NAME     = 6'd32;
    localparam t_err E_HOST_VALUE    = 6'd33;
    localparam t_err E_EMIT          = 6'd34;
    localparam t_err E_HALT_STACK    = 6'd35;
    localparam t_err E_HALT_LOCAL    = 6'd36;
    localparam t_err E_UNKNOWN       = 6'd37;
    localparam t_err E_NO_GENESIS    = 6'd38;
    localparam t_err E_NO_HALT       = 6'd39;

    typedef struct packed {
        logic [7:0]  cmd;
        logic [31:0] operand;
        logic        executor_name_ok;
        logic        adapter_name_ok;
        logic        last;
    } t_in_word;

    typedef struct packed {
        logic        ok;
        logic [5:0]  error_code;
        logic [31:0] error_at;
        logic        done_res;
    } t_out_word;

    typedef enum logic [3:0] {
        CO_HOLD,
        CO_PUSH,
        CO_POP,
        CO_POP2,
        CO_POPSET,
        CO_SET,
        CO_JOIN,
        CO_CLEAR,
        CO_SCAN
    } t_cell_op;

    // broadcast to every stack cell
    typedef struct packed {
        t_cell_op       op;
        t_type          val;
        logic [SAW-1:0] lim;
        logic           chk_missing;
    } t_cell_ctl;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_RUN  = 6'b000010,
        S_LOAD = 6'b000100,
        S_SCAN = 6'b001000,
        S_SCHK = 6'b010000,
        S_FIN  = 6'b100000
    } t_state;

    function automatic logic has(input t_type v, input t_type m);
        return |(v & m);
    endfunction

endpackage

### rtl/core/btsv_ram.sv
// ----------------------------------------------------------------------------
// btsv_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module btsv_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 64
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                            i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/btsv_cell.sv
// ----------------------------------------------------------------------------
// btsv_cell
// One type-stack cell: holds one entry and shifts with its neighbors on
// push and pop; carries a scan flag one cell toward the top per cycle.
// ----------------------------------------------------------------------------
module btsv_cell (
    input  logic                    i_clk,
    input  btsv_pkg::t_cell_ctl     i_ctl,
    input  logic [btsv_pkg::SAW-1:0] i_index,
    input  btsv_pkg::t_type         i_above,
    input  btsv_pkg::t_type         i_below1,
    input  btsv_pkg::t_type         i_below2,
    input  logic                    i_flag_below,
    output btsv_pkg::t_type         o_type,
    output logic                    o_flag
);

    btsv_pkg::t_type r_type;
    btsv_pkg::t_type n_type;
    logic            r_flag;
    logic            n_flag;
    logic            w_top;
    logic            w_win;

    assign w_top = (i_index == '0);
    assign w_win = (i_index < i_ctl.lim);

    always_comb begin
        n_type = r_type;
        n_flag = r_flag;
        unique case (i_ctl.op)
            btsv_pkg::CO_HOLD: ;
            btsv_pkg::CO_PUSH:   n_type = w_top ? i_ctl.val : i_above;
            btsv_pkg::CO_POP:    n_type = i_below1;
            btsv_pkg::CO_POP2:   n_type = i_below2;
            btsv_pkg::CO_POPSET: n_type = w_top ? i_ctl.val : i_below1;
            btsv_pkg::CO_SET: begin
                if (w_top) n_type = i_ctl.val;
            end
            btsv_pkg::CO_JOIN: begin
                if (w_win) n_type = btsv_pkg::T_DOC;
            end
            btsv_pkg::CO_CLEAR:  n_flag = 1'b0;
            // a hit anywhere in the window ripples up to the top cell
            btsv_pkg::CO_SCAN:
                n_flag = (w_win & (r_type[btsv_pkg::FUT_BIT] ^ i_ctl.chk_missing))
                         | i_flag_below;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_type <= n_type;
        r_flag <= n_flag;
    end

    assign o_type = r_type;
    assign o_flag = r_flag;

endmodule

### rtl/core/bytecode_type_stack_verifier.sv
// ----------------------------------------------------------------------------
// bytecode_type_stack_verifier
// Checks a bytecode program one instruction per word and reports the first
// type or ordering violation.
// ----------------------------------------------------------------------------
// Each instruction passes a decode-and-execute state (S_RUN) and a result
// state (S_FIN), in which the next word can be accepted. LOAD adds a state
// for the local-slot RAM read. A JOIN n that passes its count check and HALT
// on a non-empty stack also pass S_SCAN and S_SCHK: their check ripples
// through the row of stack cells one cell per cycle. A stalled result holds
// the verifier in S_FIN. After a violation, later words only report it; the
// word marked last runs the end checks and returns the verifier to its reset
// state.
module bytecode_type_stack_verifier (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  btsv_pkg::t_in_word  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output btsv_pkg::t_out_word o_out_data
);

    localparam int D = btsv_pkg::STACK_DEPTH;

    btsv_pkg::t_state              r_state, n_state;
    btsv_pkg::t_in_word            r_in, n_in;
    logic [btsv_pkg::SAW-1:0]      r_count, n_count;
    logic                          r_began, n_began;
    logic                          r_halted, n_halted;
    logic                          r_locked, n_locked;
    logic                          r_futloc, n_futloc;
    logic [btsv_pkg::LOCAL_SLOTS-1:0] r_bound, n_bound;
    btsv_pkg::t_err                r_err, n_err;
    logic [31:0]                   r_err_at, n_err_at;
    logic [31:0]                   r_icount, n_icount;
    logic [btsv_pkg::SAW-1:0]      r_lim, n_lim;
    logic                          r_join, n_join;
    logic [btsv_pkg::SAW-1:0]      r_scnt, n_scnt;
    btsv_pkg::t_out_word           r_out, n_out;
    logic                          r_out_valid, n_out_valid;

    btsv_pkg::t_cell_ctl           w_ctl;
    btsv_pkg::t_type               w_type [D + 2];
    logic                          w_flag [D + 1];
    btsv_pkg::t_type               w_top, w_sec;
    logic                          w_out_free;
    logic                          w_accept;
    logic                          w_full;
    logic                          w_one, w_two;
    logic                          w_slot_ok;
    logic [btsv_pkg::LAW-1:0]      w_slot;
    btsv_pkg::t_err                w_e;
    btsv_pkg::t_err                w_fe;
    logic [31:0]                   w_fat;
    logic                          w_ram_we;
    btsv_pkg::t_type               w_ram_rdata;

    // ---- stack cell row, cell 0 is the top ----
    assign w_type[D]     = '0;
    assign w_type[D + 1] = '0;
    assign w_flag[D]     = 1'b0;

    for (genvar gi = 0; gi < D; gi++) begin : g_cell
        btsv_pkg::t_type w_above;
        if (gi == 0) begin : g_top
            assign w_above = w_ctl.val;
        end else begin : g_mid
            assign w_above = w_type[gi - 1];
        end
        btsv_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl),
            .i_index      (btsv_pkg::SAW'(gi)),
            .i_above      (w_above),
            .i_below1     (w_type[gi + 1]),
            .i_below2     (w_type[gi + 2]),
            .i_flag_below (w_flag[gi + 1]),
            .o_type       (w_type[gi]),
            .o_flag       (w_flag[gi])
        );
    end

    assign w_slot = r_in.operand[btsv_pkg::LAW-1:0];

    btsv_ram #(
        .WIDTH (9),
        .DEPTH (btsv_pkg::LOCAL_SLOTS)
    ) u_locals (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_slot),
        .i_wdata (w_top),
        .i_raddr (w_slot),
        .o_rdata (w_ram_rdata)
    );

    assign w_top      = w_type[0];
    assign w_sec      = w_type[1];
    assign w_full     = (r_count == btsv_pkg::SAW'(D));
    assign w_one      = (r_count != '0);
    assign w_two      = (r_count >= btsv_pkg::SAW'(2));
    assign w_slot_ok  = (r_in.operand < 32'(btsv_pkg::LOCAL_SLOTS));
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = !((r_state == btsv_pkg::S_IDLE) ||
                          ((r_state == btsv_pkg::S_FIN) && w_out_free));
    assign w_accept   = i_in_valid && !o_in_stall;

    // end-of-program checks and result word
    always_comb begin
        w_fe  = r_err;
        w_fat = r_err_at;
        if (r_in.last && (r_err == btsv_pkg::E_NONE)) begin
            if (!r_began) begin
                w_fe  = btsv_pkg::E_NO_GENESIS;
                w_fat = r_icount + 32'd1;
            end else if (!r_halted) begin
                w_fe  = btsv_pkg::E_NO_HALT;
                w_fat = r_icount + 32'd1;
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_in        = r_in;
        n_count     = r_count;
        n_began     = r_began;
        n_halted    = r_halted;
        n_locked    = r_locked;
        n_futloc    = r_futloc;
        n_bound     = r_bound;
        n_err       = r_err;
        n_err_at    = r_err_at;
        n_icount    = r_icount;
        n_lim       = r_lim;
        n_join      = r_join;
        n_scnt      = r_scnt;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        w_e         = btsv_pkg::E_NONE;
        w_ram_we    = 1'b0;
        w_ctl.op          = btsv_pkg::CO_HOLD;
        w_ctl.val         = '0;
        w_ctl.lim         = r_lim;
        w_ctl.chk_missing = r_join;

        if (r_out_valid && !i_out_stall) n_out_valid = 1'b0;

        unique case (r_state)
            btsv_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_in    = i_in_data;
                    n_state = btsv_pkg::S_RUN;
                end
            end

            btsv_pkg::S_RUN: begin
                n_state = btsv_pkg::S_FIN;
                if (r_err == btsv_pkg::E_NONE) begin
                    if (r_halted) begin
                        w_e = btsv_pkg::E_AFTER_HALT;
                    end else begin
                        unique case (r_in.cmd)
                            btsv_pkg::OP_OMNI: begin
                                if (!r_in.executor_name_ok) w_e = btsv_pkg::E_EXEC_NAME;
                            end
                            btsv_pkg::OP_GENESIS: begin
                                if (r_began) w_e = btsv_pkg::E_GENESIS_TWICE;
                                else n_began = 1'b1;
                            end
                            btsv_pkg::OP_LIMIT: begin
                                if (r_locked) w_e = btsv_pkg::E_CFG_LOCKED;
                                else if (r_in.operand == '0 ||
                                         r_in.operand > btsv_pkg::LIMIT_MAX)
                                    w_e = btsv_pkg::E_LIMIT;
                            end
                            btsv_pkg::OP_RETRY: begin
                                if (r_locked) w_e = btsv_pkg::E_CFG_LOCKED;
                                else if (r_in.operand > btsv_pkg::RETRY_MAX)
                                    w_e = btsv_pkg::E_RETRY;
                            end
                            btsv_pkg::OP_BACKOFF: begin
                                if (r_locked) w_e = btsv_pkg::E_CFG_LOCKED;
                                else if (r_in.operand > btsv_pkg::BACKOFF_MAX)
                                    w_e = btsv_pkg::E_BACKOFF;
                            end
                            btsv_pkg::OP_RATE: begin
                                if (r_locked) w_e = btsv_pkg::E_CFG_LOCKED;
                                else if (r_in.operand > btsv_pkg::RATE_MAX)
                                    w_e = btsv_pkg::E_RATE;
                            end
                            btsv_pkg::OP_HUNT, btsv_pkg::OP_FORK: begin
                                if (!r_began) w_e = btsv_pkg::E_NET_EARLY;
                                else if (w_full) w_e = btsv_pkg::E_OVERFLOW;
                                else begin
                                    n_locked  = 1'b1;
                                    w_ctl.op  = btsv_pkg::CO_PUSH;
                                    w_ctl.val = (r_in.cmd == btsv_pkg::OP_FORK) ?
                                                btsv_pkg::T_FUT : btsv_pkg::T_DOC;
                                    n_count   = r_count + btsv_pkg::SAW'(1);
                                end
                            end
                            btsv_pkg::OP_CONST: begin
                                if (!r_began) w_e = btsv_pkg::E_CONST_EARLY;
                                else if (w_full) w_e = btsv_pkg::E_OVERFLOW;
                                else begin
                                    w_ctl.op  = btsv_pkg::CO_PUSH;
                                    w_ctl.val = btsv_pkg::T_STR;
                                    n_count   = r_count + btsv_pkg::SAW'(1);
                                end
                            end
                            btsv_pkg::OP_CONST_NULL, btsv_pkg::OP_CONST_BOOL,
                            btsv_pkg::OP_CONST_I64, btsv_pkg::OP_CONST_RECORD,
                            btsv_pkg::OP_CONST_LIST: begin
                                if (!r_began) w_e = btsv_pkg::E_TCONST_EARLY;
                                else if (w_full) w_e = btsv_pkg::E_OVERFLOW;
                                else begin
                                    w_ctl.op  = btsv_pkg::CO_PUSH;
                                    w_ctl.val =
                                        (r_in.cmd == btsv_pkg::OP_CONST_NULL) ? btsv_pkg::T_NULL :
                                        (r_in.cmd == btsv_pkg::OP_CONST_BOOL) ? btsv_pkg::T_BOOL :
                                        (r_in.cmd == btsv_pkg::OP_CONST_I64)  ? btsv_pkg::T_I64  :
                                        (r_in.cmd == btsv_pkg::OP_CONST_RECORD) ?
                                            btsv_pkg::T_REC : btsv_pkg::T_LIST;
                                    n_count   = r_count + btsv_pkg::SAW'(1);
                                end
                            end
                            btsv_pkg::OP_BIND: begin
                                if (!r_began || !w_one) w_e = btsv_pkg::E_BIND_EMPTY;
                                else if (!w_slot_ok || r_bound[w_slot])
                                    w_e = btsv_pkg::E_BIND_SLOT;
                                else begin
                                    w_ram_we        = 1'b1;
                                    n_bound[w_slot] = 1'b1;
                                    // bound slots never change, so one sticky bit
                                    // answers the HALT local check
                                    n_futloc = r_futloc | w_top[btsv_pkg::FUT_BIT];
                                    w_ctl.op = btsv_pkg::CO_POP;
                                    n_count  = r_count - btsv_pkg::SAW'(1);
                                end
                            end
                            btsv_pkg::OP_LOAD: begin
                                if (!r_began || !w_slot_ok || !r_bound[w_slot])
                                    w_e = btsv_pkg::E_LOAD_UNBOUND;
                                else if (w_full) w_e = btsv_pkg::E_OVERFLOW;
                                else n_state = btsv_pkg::S_LOAD;
                            end
                            btsv_pkg::OP_AWAIT: begin
                                if (!(w_one && btsv_pkg::has(w_top, btsv_pkg::T_FUT)))
                                    w_e = btsv_pkg::E_AWAIT;
                                else begin
                                    w_ctl.op  = btsv_pkg::CO_SET;
                                    w_ctl.val = btsv_pkg::T_DOC;
                                end
                            end
                            btsv_pkg::OP_JOIN: begin
                                if (r_in.operand == '0 || r_in.operand > 32'(r_count))
                                    w_e = btsv_pkg::E_JOIN_COUNT;
                                else begin
                                    w_ctl.op = btsv_pkg::CO_CLEAR;
                                    n_lim    = r_in.operand[btsv_pkg::SAW-1:0];
                                    n_join   = 1'b1;
                                    n_scnt   = '0;
                                    n_state  = btsv_pkg::S_SCAN;
                                end
                            end
                            btsv_pkg::OP_REAP: begin
                                if (!(w_one && btsv_pkg::has(w_top, btsv_pkg::T_DOC)))
                                    w_e = btsv_pkg::E_REAP;
                                else begin
                                    w_ctl.op  = btsv_pkg::CO_SET;
                                    w_ctl.val = btsv_pkg::T_TEXT;
                                end
                            end
                            btsv_pkg::OP_JSON_PATH: begin
                                if (!(w_one && btsv_pkg::has(w_top, btsv_pkg::T_DOC)))
                                    w_e = btsv_pkg::E_JSON_PATH;
                                else begin
                                    w_ctl.op  = btsv_pkg::CO_SET;
                                    w_ctl.val = btsv_pkg::T_SCALAR;
                                end
                            end
                            btsv_pkg::OP_RECORD_SET, btsv_pkg::OP_LIST_PUSH: begin
                                if (!w_two) w_e = btsv_pkg::E_MUT_COUNT;
                                else if (!btsv_pkg::has(w_sec,
                                             (r_in.cmd == btsv_pkg::OP_RECORD_SET) ?
                                             btsv_pkg::T_REC : btsv_pkg::T_LIST) ||
                                         !btsv_pkg::has(w_top, btsv_pkg::T_VALUE))
                                    w_e = btsv_pkg::E_MUT_TYPE;
                                else begin
                                    w_ctl.op = btsv_pkg::CO_POP2;
                                    n_count  = r_count - btsv_pkg::SAW'(2);
                                end
                            end
                            btsv_pkg::OP_RECORD_GET, btsv_pkg::OP_RECORD_GET_O: begin
                                if (!(w_one && btsv_pkg::has(w_top, btsv_pkg::T_REC)))
                                    w_e = btsv_pkg::E_REC_READ;
                                else begin
                                    w_ctl.op  = btsv_pkg::CO_SET;
                                    w_ctl.val = btsv_pkg::T_VALUE;
                                end
                            end
                            btsv_pkg::OP_LIST_AT, btsv_pkg::OP_LIST_AT_O: begin
                                if (!(w_one && btsv_pkg::has(w_top, btsv_pkg::T_LIST)))
                                    w_e = btsv_pkg::E_LIST_READ;
                                else begin
                                    w_ctl.op  = btsv_pkg::CO_SET;
                                    w_ctl.val = btsv_pkg::T_VALUE;
                                end
                            end
                            btsv_pkg::OP_BOOL_NOT: begin
                                if (!(w_one && btsv_pkg::has(w_top, btsv_pkg::T_BOOL)))
                                    w_e = btsv_pkg::E_NOT;
                                else begin
                                    w_ctl.op  = btsv_pkg::CO_SET;
                                    w_ctl.val = btsv_pkg::T_BOOL;
                                end
                            end
                            btsv_pkg::OP_BOOL_AND, btsv_pkg::OP_BOOL_OR: begin
                                if (!(w_two && btsv_pkg::has(w_sec, btsv_pkg::T_BOOL) &&
                                      btsv_pkg::has(w_top, btsv_pkg::T_BOOL)))
                                    w_e = btsv_pkg::E_BOOL_OP;
                                else begin
                                    w_ctl.op  = btsv_pkg::CO_POPSET;
                                    w_ctl.val = btsv_pkg::T_BOOL;
                                    n_count   = r_count - btsv_pkg::SAW'(1);
                                end
                            end
                            btsv_pkg::OP_LESS, btsv_pkg::OP_LESS_EQUAL,
                            btsv_pkg::OP_GREATER, btsv_pkg::OP_GREATER_EQ: begin
                                if (!(w_two && btsv_pkg::has(w_sec, btsv_pkg::T_I64) &&
                                      btsv_pkg::has(w_top, btsv_pkg::T_I64)))
                                    w_e = btsv_pkg::E_ORDER;
                                else begin
                                    w_ctl.op  = btsv_pkg::CO_POPSET;
                                    w_ctl.val = btsv_pkg::T_BOOL;
                                    n_count   = r_count - btsv_pkg::SAW'(1);
                                end
                            end
                            btsv_pkg::OP_EQUAL, btsv_pkg::OP_NOT_EQUAL,
                            btsv_pkg::OP_COALESCE: begin
                                if (!w_two) w_e = btsv_pkg::E_BINARY;
                                else begin
                                    w_ctl.op  = btsv_pkg::CO_POPSET;
                                    w_ctl.val = (r_in.cmd == btsv_pkg::OP_COALESCE) ?
                                                (w_sec | w_top) : btsv_pkg::T_BOOL;
                                    n_count   = r_count - btsv_pkg::SAW'(1);
                                end
                            end
                            btsv_pkg::OP_TO_TEXT, btsv_pkg::OP_TO_I64,
                            btsv_pkg::OP_TO_BOOL, btsv_pkg::OP_URL_ENCODE: begin
                                if (!(w_one && btsv_pkg::has(w_top, btsv_pkg::T_STR |
                                      btsv_pkg::T_TEXT | btsv_pkg::T_BOOL |
                                      btsv_pkg::T_I64)))
                                    w_e = btsv_pkg::E_CONVERT;
                                else begin
                                    w_ctl.op  = btsv_pkg::CO_SET;
                                    w_ctl.val =
                                        (r_in.cmd == btsv_pkg::OP_TO_I64)  ? btsv_pkg::T_I64 :
                                        (r_in.cmd == btsv_pkg::OP_TO_BOOL) ? btsv_pkg::T_BOOL :
                                        btsv_pkg::T_STR;
                                end
                            end
                            btsv_pkg::OP_URL_JOIN: begin
                                if (!(w_two &&
                                      btsv_pkg::has(w_sec, btsv_pkg::T_STR | btsv_pkg::T_TEXT) &&
                                      btsv_pkg::has(w_top, btsv_pkg::T_STR | btsv_pkg::T_TEXT)))
                                    w_e = btsv_pkg::E_URL_JOIN;
                                else begin
                                    w_ctl.op  = btsv_pkg::CO_POPSET;
                                    w_ctl.val = btsv_pkg::T_STR;
                                    n_count   = r_count - btsv_pkg::SAW'(1);
                                end
                            end
                            btsv_pkg::OP_HUNT_VALUE: begin
                                if (!r_began || !(w_one && btsv_pkg::has(w_top,
                                      btsv_pkg::T_STR | btsv_pkg::T_TEXT)))
                                    w_e = btsv_pkg::E_HUNT_VALUE;
                                else begin
                                    n_locked  = 1'b1;
                                    w_ctl.op  = btsv_pkg::CO_SET;
                                    w_ctl.val = btsv_pkg::T_DOC;
                                end
                            end
                            btsv_pkg::OP_HOST_CALL: begin
                                if (!r_began || !r_in.adapter_name_ok)
                                    w_e = btsv_pkg::E_HOST_NAME;
                                else if (!(w_one && btsv_pkg::has(w_top, btsv_pkg::T_VALUE)))
                                    w_e = btsv_pkg::E_HOST_VALUE;
                                else begin
                                    n_locked  = 1'b1;
                                    w_ctl.op  = btsv_pkg::CO_SET;
                                    w_ctl.val = btsv_pkg::T_VALUE;
                                end
                            end
                            btsv_pkg::OP_EMIT: begin
                                if (!(w_one && btsv_pkg::has(w_top, btsv_pkg::T_VALUE)))
                                    w_e = btsv_pkg::E_EMIT;
                                else begin
                                    w_ctl.op = btsv_pkg::CO_POP;
                                    n_count  = r_count - btsv_pkg::SAW'(1);
                                end
                            end
                            btsv_pkg::OP_HALT: begin
                                if (w_one) begin
                                    w_ctl.op = btsv_pkg::CO_CLEAR;
                                    n_lim    = r_count;
                                    n_join   = 1'b0;
                                    n_scnt   = '0;
                                    n_state  = btsv_pkg::S_SCAN;
                                end else if (r_futloc) w_e = btsv_pkg::E_HALT_LOCAL;
                                else n_halted = 1'b1;
                            end
                            default: w_e = btsv_pkg::E_UNKNOWN;
                        endcase
                    end
                end
            end

            btsv_pkg::S_LOAD: begin
                w_ctl.op  = btsv_pkg::CO_PUSH;
                w_ctl.val = w_ram_rdata;
                n_count   = r_count + btsv_pkg::SAW'(1);
                n_state   = btsv_pkg::S_FIN;
            end

            // when S_SCAN ends, cell 0's flag covers cells 0..r_lim-1
            btsv_pkg::S_SCAN: begin
                w_ctl.op = btsv_pkg::CO_SCAN;
                n_scnt   = r_scnt + btsv_pkg::SAW'(1);
                if (r_scnt == r_lim - btsv_pkg::SAW'(1)) n_state = btsv_pkg::S_SCHK;
            end

            btsv_pkg::S_SCHK: begin
                n_state = btsv_pkg::S_FIN;
                if (r_join) begin
                    if (w_flag[0]) w_e = btsv_pkg::E_JOIN_TYPE;
                    else w_ctl.op = btsv_pkg::CO_JOIN;
                end else begin
                    if (w_flag[0]) w_e = btsv_pkg::E_HALT_STACK;
                    else if (r_futloc) w_e = btsv_pkg::E_HALT_LOCAL;
                    else n_halted = 1'b1;
                end
            end

            btsv_pkg::S_FIN: begin
                if (w_out_free) begin
                    n_out.ok         = (w_fe == btsv_pkg::E_NONE);
                    n_out.error_code = w_fe;
                    n_out.error_at   = (w_fe == btsv_pkg::E_NONE) ? 32'd0 : w_fat;
                    n_out.done_res   = r_in.last;
                    n_out_valid      = 1'b1;
                    n_icount         = r_icount + 32'd1;
                    if (r_in.last) begin
                        n_count  = '0;
                        n_began  = 1'b0;
                        n_halted = 1'b0;
                        n_locked = 1'b0;
                        n_futloc = 1'b0;
                        n_bound  = '0;
                        n_err    = btsv_pkg::E_NONE;
                        n_err_at = '0;
                        n_icount = '0;
                    end
                    if (w_accept) begin
                        n_in    = i_in_data;
                        n_state = btsv_pkg::S_RUN;
                    end else begin
                        n_state = btsv_pkg::S_IDLE;
                    end
                end
            end

            default: n_state = btsv_pkg::S_IDLE;
        endcase

        if (w_e != btsv_pkg::E_NONE) begin
            n_err    = w_e;
            n_err_at = r_icount;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= btsv_pkg::S_IDLE;
            r_count     <= '0;
            r_began     <= 1'b0;
            r_halted    <= 1'b0;
            r_locked    <= 1'b0;
            r_futloc    <= 1'b0;
            r_bound     <= '0;
            r_err       <= btsv_pkg::E_NONE;
            r_err_at    <= '0;
            r_icount    <= '0;
            r_lim       <= '0;
            r_join      <= 1'b0;
            r_scnt      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_began     <= n_began;
            r_halted    <= n_halted;
            r_locked    <= n_locked;
            r_futloc    <= n_futloc;
            r_bound     <= n_bound;
            r_err       <= n_err;
            r_err_at    <= n_err_at;
            r_icount    <= n_icount;
            r_lim       <= n_lim;
            r_join      <= n_join;
            r_scnt      <= n_scnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in  <= n_in;
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= btsv_pkg::SAW'(D))
        else $error("stack count beyond depth");

    a_err_freezes_stack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_err != btsv_pkg::E_NONE && r_state != btsv_pkg::S_FIN) |=> $stable(r_count))
        else $error("stack moved after a latched violation");

    a_scan_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == btsv_pkg::S_SCAN) |-> (r_lim != '0 && r_scnt < r_lim))
        else $error("scan counter out of window");

    a_ok_matches_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.ok == (o_out_data.error_code == btsv_pkg::E_NONE)))
        else $error("ok flag disagrees with error code");

endmodule

### sim/bytecode_type_stack_verifier_test.sv
// ----------------------------------------------------------------------------
// bytecode_type_stack_verifier_test
// Drives bytecode programs into the verifier: a directed table, one stack-overflow
// program, then random programs steered toward valid instructions. Each result word
// is checked against an in-bench type-stack model or a table row's expected word.
// ----------------------------------------------------------------------------
module bytecode_type_stack_verifier_test;

    localparam int WD_LIMIT = 6000;
    localparam int N_ITEMS  = 1950;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    btsv_pkg::t_in_word   i_in_data = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    btsv_pkg::t_out_word  o_out_data;

    bytecode_type_stack_verifier u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always #6 i_clk = ~i_clk;

    // type-stack model state
    btsv_pkg::t_type     stk [btsv_pkg::STACK_DEPTH];
    int                  cnt;
    btsv_pkg::t_type     loc [btsv_pkg::LOCAL_SLOTS];
    bit                  bnd [btsv_pkg::LOCAL_SLOTS];
    bit                  began, halted, locked;
    btsv_pkg::t_err      first;
    logic [31:0]         pos, icnt;

    // snapshot for trial steps
    btsv_pkg::t_type     stk_s [btsv_pkg::STACK_DEPTH];
    int                  cnt_s;
    btsv_pkg::t_type     loc_s [btsv_pkg::LOCAL_SLOTS];
    bit                  bnd_s [btsv_pkg::LOCAL_SLOTS];
    bit                  began_s, halted_s, locked_s;
    btsv_pkg::t_err      first_s;
    logic [31:0]         pos_s, icnt_s;

    btsv_pkg::t_out_word result_q[$];
    bit                  failed = 1'b0;
    bit                  quiet = 1'b0;
    int                  idle_cycles = 0;
    int                  sent = 0;

    function automatic void clear_model();
        cnt = 0; began = 0; halted = 0; locked = 0;
        first = btsv_pkg::E_NONE; pos = '0; icnt = '0;
        foreach (bnd[i]) bnd[i] = 1'b0;
    endfunction

    function automatic void save_model();
        stk_s = stk; cnt_s = cnt; loc_s = loc; bnd_s = bnd;
        began_s = began; halted_s = halted; locked_s = locked;
        first_s = first; pos_s = pos; icnt_s = icnt;
    endfunction

    function automatic void restore_model();
        stk = stk_s; cnt = cnt_s; loc = loc_s; bnd = bnd_s;
        began = began_s; halted = halted_s; locked = locked_s;
        first = first_s; pos = pos_s; icnt = icnt_s;
    endfunction

    function automatic bit top_is(btsv_pkg::t_type m);
        return cnt != 0 && (stk[cnt-1] & m) != '0;
    endfunction

    function automatic bit two_are(btsv_pkg::t_type m);
        return cnt >= 2 && (stk[cnt-2] & m) != '0 && (stk[cnt-1] & m) != '0;
    endfunction

    function automatic btsv_pkg::t_err push_type(btsv_pkg::t_type t);
        if (cnt >= btsv_pkg::STACK_DEPTH) return btsv_pkg::E_OVERFLOW;
        stk[cnt] = t;
        cnt++;
        return btsv_pkg::E_NONE;
    endfunction

    function automatic btsv_pkg::t_err cfg_err(btsv_pkg::t_err code, bit bad);
        if (locked) return btsv_pkg::E_CFG_LOCKED;
        return bad ? code : btsv_pkg::E_NONE;
    endfunction

    function automatic btsv_pkg::t_err exec_word(btsv_pkg::t_in_word w);
        logic [31:0] n;
        btsv_pkg::t_type l, r;
        n = w.operand;
        if (halted) return btsv_pkg::E_AFTER_HALT;
        case (w.cmd)
            btsv_pkg::OP_OMNI:
                return w.executor_name_ok ? btsv_pkg::E_NONE : btsv_pkg::E_EXEC_NAME;
            btsv_pkg::OP_GENESIS: begin
                if (began) return btsv_pkg::E_GENESIS_TWICE;
                began = 1; return btsv_pkg::E_NONE;
            end
            btsv_pkg::OP_LIMIT:
                return cfg_err(btsv_pkg::E_LIMIT, n == 0 || n > btsv_pkg::LIMIT_MAX);
            btsv_pkg::OP_RETRY:   return cfg_err(btsv_pkg::E_RETRY, n > btsv_pkg::RETRY_MAX);
            btsv_pkg::OP_BACKOFF:
                return cfg_err(btsv_pkg::E_BACKOFF, n > btsv_pkg::BACKOFF_MAX);
            btsv_pkg::OP_RATE:    return cfg_err(btsv_pkg::E_RATE, n > btsv_pkg::RATE_MAX);
            btsv_pkg::OP_HUNT, btsv_pkg::OP_FORK: begin
                if (!began) return btsv_pkg::E_NET_EARLY;
                if (cnt >= btsv_pkg::STACK_DEPTH) return btsv_pkg::E_OVERFLOW;
                locked = 1;
                return push_type(w.cmd == btsv_pkg::OP_FORK ? btsv_pkg::T_FUT :
                                 btsv_pkg::T_DOC);
            end
            btsv_pkg::OP_CONST: begin
                if (!began) return btsv_pkg::E_CONST_EARLY;
                return push_type(btsv_pkg::T_STR);
            end
            btsv_pkg::OP_CONST_NULL, btsv_pkg::OP_CONST_BOOL, btsv_pkg::OP_CONST_I64,
            btsv_pkg::OP_CONST_RECORD, btsv_pkg::OP_CONST_LIST: begin
                if (!began) return btsv_pkg::E_TCONST_EARLY;
                case (w.cmd)
                    btsv_pkg::OP_CONST_NULL:   return push_type(btsv_pkg::T_NULL);
                    btsv_pkg::OP_CONST_BOOL:   return push_type(btsv_pkg::T_BOOL);
                    btsv_pkg::OP_CONST_I64:    return push_type(btsv_pkg::T_I64);
                    btsv_pkg::OP_CONST_RECORD: return push_type(btsv_pkg::T_REC);
                    default:                   return push_type(btsv_pkg::T_LIST);
                endcase
            end
            btsv_pkg::OP_BIND: begin
                if (!began || cnt == 0) return btsv_pkg::E_BIND_EMPTY;
                if (n >= btsv_pkg::LOCAL_SLOTS || bnd[n]) return btsv_pkg::E_BIND_SLOT;
                cnt--;
                loc[n] = stk[cnt];
                bnd[n] = 1;
                return btsv_pkg::E_NONE;
            end
            btsv_pkg::OP_LOAD: begin
                if (!began || n >= btsv_pkg::LOCAL_SLOTS || !bnd[n])
                    return btsv_pkg::E_LOAD_UNBOUND;
                return push_type(loc[n]);
            end
            btsv_pkg::OP_AWAIT: begin
                if (!top_is(btsv_pkg::T_FUT)) return btsv_pkg::E_AWAIT;
                stk[cnt-1] = btsv_pkg::T_DOC; return btsv_pkg::E_NONE;
            end
            btsv_pkg::OP_JOIN: begin
                if (n == 0 || n > cnt) return btsv_pkg::E_JOIN_COUNT;
                for (int i = cnt - int'(n); i < cnt; i++) begin
                    if ((stk[i] & btsv_pkg::T_FUT) == '0) return btsv_pkg::E_JOIN_TYPE;
                    stk[i] = btsv_pkg::T_DOC;
                end
                return btsv_pkg::E_NONE;
            end
            btsv_pkg::OP_REAP: begin
                if (!top_is(btsv_pkg::T_DOC)) return btsv_pkg::E_REAP;
                stk[cnt-1] = btsv_pkg::T_TEXT; return btsv_pkg::E_NONE;
            end
            btsv_pkg::OP_JSON_PATH: begin
                if (!top_is(btsv_pkg::T_DOC)) return btsv_pkg::E_JSON_PATH;
                stk[cnt-1] = btsv_pkg::T_SCALAR; return btsv_pkg::E_NONE;
            end
            btsv_pkg::OP_RECORD_SET, btsv_pkg::OP_LIST_PUSH: begin
                if (cnt < 2) return btsv_pkg::E_MUT_COUNT;
                if ((stk[cnt-2] & (w.cmd == btsv_pkg::OP_RECORD_SET ? btsv_pkg::T_REC :
                                   btsv_pkg::T_LIST)) == '0 ||
                    (stk[cnt-1] & btsv_pkg::T_VALUE) == '0) return btsv_pkg::E_MUT_TYPE;
                cnt -= 2; return btsv_pkg::E_NONE;
            end
            btsv_pkg::OP_RECORD_GET, btsv_pkg::OP_RECORD_GET_O: begin
                if (!top_is(btsv_pkg::T_REC)) return btsv_pkg::E_REC_READ;
                stk[cnt-1] = btsv_pkg::T_VALUE; return btsv_pkg::E_NONE;
            end
            btsv_pkg::OP_LIST_AT, btsv_pkg::OP_LIST_AT_O: begin
                if (!top_is(btsv_pkg::T_LIST)) return btsv_pkg::E_LIST_READ;
                stk[cnt-1] = btsv_pkg::T_VALUE; return btsv_pkg::E_NONE;
            end
            btsv_pkg::OP_BOOL_NOT: begin
                if (!top_is(btsv_pkg::T_BOOL)) return btsv_pkg::E_NOT;
                stk[cnt-1] = btsv_pkg::T_BOOL; return btsv_pkg::E_NONE;
            end
            btsv_pkg::OP_BOOL_AND, btsv_pkg::OP_BOOL_OR: begin
                if (!two_are(btsv_pkg::T_BOOL)) return btsv_pkg::E_BOOL_OP;
                cnt--; stk[cnt-1] = btsv_pkg::T_BOOL; return btsv_pkg::E_NONE;
            end
            btsv_pkg::OP_LESS, btsv_pkg::OP_LESS_EQUAL, btsv_pkg::OP_GREATER,
            btsv_pkg::OP_GREATER_EQ: begin
                if (!two_are(btsv_pkg::T_I64)) return btsv_pkg::E_ORDER;
                cnt--; stk[cnt-1] = btsv_pkg::T_BOOL; return btsv_pkg::E_NONE;
            end
            btsv_pkg::OP_EQUAL, btsv_pkg::OP_NOT_EQUAL, btsv_pkg::OP_COALESCE: begin
                if (cnt < 2) return btsv_pkg::E_BINARY;
                l = stk[cnt-2]; r = stk[cnt-1];
                cnt--;
                stk[cnt-1] = (w.cmd == btsv_pkg::OP_COALESCE) ? (l | r) : btsv_pkg::T_BOOL;
                return btsv_pkg::E_NONE;
            end
            btsv_pkg::OP_TO_TEXT, btsv_pkg::OP_TO_I64, btsv_pkg::OP_TO_BOOL,
            btsv_pkg::OP_URL_ENCODE: begin
                if (!top_is(btsv_pkg::T_STR | btsv_pkg::T_TEXT | btsv_pkg::T_BOOL |
                            btsv_pkg::T_I64)) return btsv_pkg::E_CONVERT;
                stk[cnt-1] = (w.cmd == btsv_pkg::OP_TO_I64) ? btsv_pkg::T_I64 :
                             (w.cmd == btsv_pkg::OP_TO_BOOL) ? btsv_pkg::T_BOOL :
                             btsv_pkg::T_STR;
                return btsv_pkg::E_NONE;
            end
            btsv_pkg::OP_URL_JOIN: begin
                if (!two_are(btsv_pkg::T_STR | btsv_pkg::T_TEXT)) return btsv_pkg::E_URL_JOIN;
                cnt--; stk[cnt-1] = btsv_pkg::T_STR; return btsv_pkg::E_NONE;
            end
            btsv_pkg::OP_HUNT_VALUE: begin
                if (!began || !top_is(btsv_pkg::T_STR | btsv_pkg::T_TEXT))
                    return btsv_pkg::E_HUNT_VALUE;
                locked = 1; stk[cnt-1] = btsv_pkg::T_DOC; return btsv_pkg::E_NONE;
            end
            btsv_pkg::OP_HOST_CALL: begin
                if (!began || !w.adapter_name_ok) return btsv_pkg::E_HOST_NAME;
                if (!top_is(btsv_pkg::T_VALUE)) return btsv_pkg::E_HOST_VALUE;
                locked = 1; stk[cnt-1] = btsv_pkg::T_VALUE; return btsv_pkg::E_NONE;
            end
            btsv_pkg::OP_EMIT: begin
                if (!top_is(btsv_pkg::T_VALUE)) return btsv_pkg::E_EMIT;
                cnt--; return btsv_pkg::E_NONE;
            end
            btsv_pkg::OP_HALT: begin
                for (int i = 0; i < cnt; i++)
                    if ((stk[i] & btsv_pkg::T_FUT) != '0) return btsv_pkg::E_HALT_STACK;
                for (int i = 0; i < btsv_pkg::LOCAL_SLOTS; i++)
                    if (bnd[i] && (loc[i] & btsv_pkg::T_FUT) != '0)
                        return btsv_pkg::E_HALT_LOCAL;
                halted = 1; return btsv_pkg::E_NONE;
            end
            default: return btsv_pkg::E_UNKNOWN;
        endcase
    endfunction

    function automatic btsv_pkg::t_out_word verify_word(btsv_pkg::t_in_word w);
        btsv_pkg::t_out_word o;
        logic [31:0] idx;
        btsv_pkg::t_err e;
        idx = icnt;
        icnt = icnt + 1;
        if (first == btsv_pkg::E_NONE) begin
            e = exec_word(w);
            if (e != btsv_pkg::E_NONE) begin
                first = e; pos = idx;
            end
        end
        if (w.last && first == btsv_pkg::E_NONE) begin
            if (!began) begin
                first = btsv_pkg::E_NO_GENESIS; pos = icnt;
            end else if (!halted) begin
                first = btsv_pkg::E_NO_HALT; pos = icnt;
            end
        end
        o.ok = (first == btsv_pkg::E_NONE);
        o.error_code = first;
        o.error_at = (first == btsv_pkg::E_NONE) ? '0 : pos;
        o.done_res = w.last;
        if (w.last) clear_model();
        return o;
    endfunction

    function automatic btsv_pkg::t_in_word mk(logic [7:0] c, logic [31:0] n, bit ex,
                                              bit ad, bit lst);
        btsv_pkg::t_in_word w;
        w.cmd = c; w.operand = n; w.executor_name_ok = ex;
        w.adapter_name_ok = ad; w.last = lst;
        return w;
    endfunction

    function automatic btsv_pkg::t_out_word rw(bit ok, btsv_pkg::t_err code,
                                               logic [31:0] at);
        btsv_pkg::t_out_word o;
        o.ok = ok; o.error_code = code; o.error_at = at; o.done_res = 1'b1;
        return o;
    endfunction

    function automatic int pick_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    // candidate instruction, with an operand usually suited to its opcode
    function automatic btsv_pkg::t_in_word rand_word(bit lst);
        btsv_pkg::t_in_word w;
        w = mk(8'($urandom_range(0, 44)), $urandom, $urandom_range(0, 9) != 0,
               $urandom_range(0, 9) != 0, lst);
        case (w.cmd)
            btsv_pkg::OP_LIMIT:
                if ($urandom_range(0, 3) != 0) w.operand = $urandom_range(1, 256);
            btsv_pkg::OP_RETRY:
                if ($urandom_range(0, 3) != 0) w.operand = $urandom_range(0, 16);
            btsv_pkg::OP_BACKOFF:
                if ($urandom_range(0, 3) != 0) w.operand = $urandom_range(0, 60000);
            btsv_pkg::OP_RATE:
                if ($urandom_range(0, 3) != 0) w.operand = $urandom_range(0, 10000);
            btsv_pkg::OP_BIND, btsv_pkg::OP_LOAD:
                if ($urandom_range(0, 9) != 0)
                    w.operand = $urandom_range(0, btsv_pkg::LOCAL_SLOTS);
            btsv_pkg::OP_JOIN:
                if ($urandom_range(0, 9) != 0) w.operand = $urandom_range(0, 4);
            default: ;
        endcase
        return w;
    endfunction

    // try up to 12 candidates, keep the first one that does not trip an error, else the last
    function automatic btsv_pkg::t_in_word steer_word(bit lst);
        btsv_pkg::t_in_word w;
        btsv_pkg::t_out_word o;
        for (int k = 0; k < 12; k++) begin
            w = (lst && k < 6) ? mk(btsv_pkg::OP_HALT, $urandom, 1, 1, 1) : rand_word(lst);
            save_model();
            o = verify_word(w);
            restore_model();
            if (o.ok) return w;
        end
        return w;
    endfunction

    task automatic send_word(btsv_pkg::t_in_word w, btsv_pkg::t_out_word e, bit typed);
        btsv_pkg::t_out_word p;
        int gap;
        p = verify_word(w);
        result_q.push_back(typed ? e : p);
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= w;
        do @(negedge i_clk); while (o_in_stall);
        @(posedge i_clk);
        sent++;
    endtask

    // receiver stall: short bursts, rare long ones, quiet stretches
    int stall_left = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n || quiet) begin
            i_out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            int r;
            r = $urandom_range(0, 99);
            if (r < 70) begin
                i_out_stall <= 1'b0;
            end else if (r < 96) begin
                i_out_stall <= 1'b1;
                stall_left <= $urandom_range(0, 2);
            end else begin
                i_out_stall <= 1'b1;
                stall_left <= $urandom_range(5, 40);
            end
        end
    end

    int cyc = 0;
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc % 700 == 699) quiet <= ~quiet;
    end

    // result check and watchdog; values are stable between edges
    always @(negedge i_clk) begin
        btsv_pkg::t_out_word e;
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles > WD_LIMIT) begin
                $display("%0t: watchdog timeout", $time);
                $display("bytecode_type_stack_verifier test failed");
                $finish;
            end
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (result_q.size() == 0) begin
                $display("%0t: unexpected word %p", $time, o_out_data);
                failed = 1'b1;
            end else begin
                e = result_q.pop_front();
                if (o_out_data.ok !== e.ok || o_out_data.error_code !== e.error_code ||
                    o_out_data.error_at !== e.error_at ||
                    o_out_data.done_res !== e.done_res) begin
                    $display("%0t: mismatch expected ok=%0d code=%0d at=%0d done=%0d",
                             $time, e.ok, e.error_code, e.error_at, e.done_res);
                    $display("%0t:          actual ok=%0d code=%0d at=%0d done=%0d",
                             $time, o_out_data.ok, o_out_data.error_code,
                             o_out_data.error_at, o_out_data.done_res);
                    failed = 1'b1;
                end
            end
        end
    end

    typedef struct {
        btsv_pkg::t_in_word  w;
        bit                  typed;
        btsv_pkg::t_out_word e;
    } t_row;

    t_row dir_tab[$];

    task automatic add_row(btsv_pkg::t_in_word w, bit typed = 0,
                           btsv_pkg::t_out_word e = '0);
        t_row r;
        r.w = w; r.typed = typed; r.e = e;
        dir_tab.push_back(r);
    endtask

    initial begin
        int len;
        clear_model();
        // single-word programs
        add_row(mk(btsv_pkg::OP_OMNI, 0, 0, 0, 1), 1, rw(0, btsv_pkg::E_EXEC_NAME, 0));
        add_row(mk(8'hFF, 32'hFFFF_FFFF, 1, 1, 1), 1, rw(0, btsv_pkg::E_UNKNOWN, 0));
        add_row(mk(btsv_pkg::OP_HALT, 0, 1, 1, 1), 1, rw(0, btsv_pkg::E_NO_GENESIS, 1));
        add_row(mk(btsv_pkg::OP_GENESIS, 0, 1, 1, 1), 1, rw(0, btsv_pkg::E_NO_HALT, 1));
        add_row(mk(btsv_pkg::OP_LIMIT, 0, 1, 1, 1), 1, rw(0, btsv_pkg::E_LIMIT, 0));
        // config limits at their maxima, then most opcode classes
        add_row(mk(btsv_pkg::OP_OMNI, 7, 1, 0, 0));
        add_row(mk(btsv_pkg::OP_GENESIS, 0, 0, 0, 0));
        add_row(mk(btsv_pkg::OP_LIMIT, 256, 0, 0, 0));
        add_row(mk(btsv_pkg::OP_RETRY, 16, 0, 0, 0));
        add_row(mk(btsv_pkg::OP_BACKOFF, 60000, 0, 0, 0));
        add_row(mk(btsv_pkg::OP_RATE, 10000, 0, 0, 0));
        add_row(mk(btsv_pkg::OP_FORK, 32'hFFFF_FFFF, 0, 0, 0));
        add_row(mk(btsv_pkg::OP_AWAIT, 0, 0, 0, 0));
        add_row(mk(btsv_pkg::OP_REAP, 0, 0, 0, 0));
        add_row(mk(btsv_pkg::OP_CONST_I64, 0, 0, 0, 0));
        add_row(mk(btsv_pkg::OP_CONST_I64, 0, 0, 0, 0));
        add_row(mk(btsv_pkg::OP_LESS, 0, 0, 0, 0));
        add_row(mk(btsv_pkg::OP_BIND, btsv_pkg::LOCAL_SLOTS - 1, 0, 0, 0));
        add_row(mk(btsv_pkg::OP_LOAD, btsv_pkg::LOCAL_SLOTS - 1, 0, 0, 0));
        add_row(mk(btsv_pkg::OP_TO_TEXT, 0, 0, 0, 0));
        add_row(mk(btsv_pkg::OP_CONST, 0, 0, 0, 0));
        add_row(mk(btsv_pkg::OP_URL_JOIN, 0, 0, 0, 0));
        add_row(mk(btsv_pkg::OP_HUNT_VALUE, 0, 0, 0, 0));
        add_row(mk(btsv_pkg::OP_JSON_PATH, 0, 0, 0, 0));
        add_row(mk(btsv_pkg::OP_HOST_CALL, 0, 0, 1, 0));
        add_row(mk(btsv_pkg::OP_EMIT, 0, 0, 0, 0));
        add_row(mk(btsv_pkg::OP_HALT, 0, 0, 0, 1), 1, rw(1, btsv_pkg::E_NONE, 0));
        // config after a network op
        add_row(mk(btsv_pkg::OP_GENESIS, 0, 1, 1, 0));
        add_row(mk(btsv_pkg::OP_HUNT, 0, 1, 1, 0));
        add_row(mk(btsv_pkg::OP_RATE, 0, 1, 1, 1), 1, rw(0, btsv_pkg::E_CFG_LOCKED, 2));

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[i]) send_word(dir_tab[i].w, dir_tab[i].e, dir_tab[i].typed);

        // fill the stack to the top, then one push too many
        send_word(mk(btsv_pkg::OP_GENESIS, 0, 1, 1, 0), '0, 0);
        for (int i = 0; i <= btsv_pkg::STACK_DEPTH; i++)
            send_word(mk(8'($urandom_range(btsv_pkg::OP_CONST, btsv_pkg::OP_CONST_LIST)),
                         $urandom, 1, 1, 0), '0, 0);
        send_word(mk(btsv_pkg::OP_HALT, 0, 1, 1, 1), '0, 0);

        while (sent < N_ITEMS) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 40);
            for (int k = 0; k < len; k++) begin
                btsv_pkg::t_in_word w;
                bit lst;
                lst = (k == len - 1);
                if (k == 0 && $urandom_range(0, 9) != 0)
                    w = mk(btsv_pkg::OP_GENESIS, $urandom, 1'($urandom), 1'($urandom), lst);
                else if ($urandom_range(0, 99) < 85)
                    w = steer_word(lst);
                else if ($urandom_range(0, 3) == 0)
                    w = mk(8'($urandom_range(45, 255)), $urandom, 1'($urandom),
                           1'($urandom), lst);
                else
                    w = mk(8'($urandom_range(0, 44)), $urandom, 1'($urandom),
                           1'($urandom), lst);
                send_word(w, '0, 0);
            end
        end

        i_in_valid <= 1'b0;
        while (result_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (!failed && result_q.size() == 0)
            $display("bytecode_type_stack_verifier test passed");
        else
            $display("bytecode_type_stack_verifier test failed");
        $finish;
    end

endmodule

### bytecode_type_stack_verifier.f
rtl/core/btsv_pkg.sv
rtl/core/btsv_ram.sv
rtl/core/btsv_cell.sv
rtl/core/bytecode_type_stack_verifier.sv
sim/bytecode_type_stack_verifier_test.sv
